// ----- hw/rtl/tcp_pkg.sv -----
// Shared types, constants and command codes of the compressor protection thermostat.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tcp_pkg;

    // Number of cabinets with their own guard counters.
    localparam int CABINETS  = 8;
    localparam int CAB_IDX_W = $clog2(CABINETS);

    // APB register file.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_WIN_START  = 2'd0;
    localparam logic [1:0] REG_WIN_STOP   = 2'd1;
    localparam logic [1:0] REG_TARGET     = 2'd2;
    localparam logic [1:0] REG_HEAT_MODE  = 2'd3;

    // Relay command codes.
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    // Classification of a word by the front end.
    localparam logic [1:0] CLS_IGNORE = 2'd0;
    localparam logic [1:0] CLS_SHUT   = 2'd1;
    localparam logic [1:0] CLS_COOL   = 2'd2;
    localparam logic [1:0] CLS_HEAT   = 2'd3;

    // Schedule encodings with special meaning.
    localparam logic [11:0] HHMM_ALWAYS_ON = 12'd0;
    localparam logic [11:0] HHMM_OFF       = 12'd2359;

    // Division by 100 of a 12-bit value: (v * 1311) >> 17 is exact up to 4095.
    localparam int HHMM_RECIP = 1311;
    localparam int HHMM_SHIFT = 17;
    localparam int HHMM_Q_W   = 6;

    // Thermal limits, in whole degrees, on a 10-bit signed scale.
    localparam logic signed [9:0] HYST_DEG     = 10'sd4;
    localparam logic signed [9:0] HEAT_MAX_DEG = 10'sd30;

    // Guard counters.
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] OFF_GUARD_MIN = 16'd42;
    localparam logic [CNT_W-1:0] RUN_LIMIT     = 16'd318;

    // Configuration as seen by the front end, with pre-divided schedule hours.
    typedef struct packed {
        logic [11:0]         win_start;
        logic [11:0]         win_stop;
        logic [HHMM_Q_W-1:0] start_q;
        logic [HHMM_Q_W-1:0] stop_q;
        logic signed [7:0]   target_temp;
        logic                heat_mode;
    } tcp_cfg_t;

    // Input word as accepted.
    typedef struct packed {
        logic [2:0]        cabinet;
        logic              board_ok;
        logic              probe_ok;
        logic signed [7:0] cabinet_temp;
        logic              compressor_on;
        logic              heater_on;
        logic              door_open;
        logic [10:0]       minute_of_day;
    } tcp_item_t;

    // Classified work for the back end.
    typedef struct packed {
        logic [2:0] cabinet;
        logic [1:0] cls;
        logic       hot;        // temperature at or above target plus hysteresis
        logic       cool_done;  // temperature at or below target
        logic       cold;       // heating may start
        logic       heat_done;  // heating must stop
        logic       comp_on;
        logic       heat_on;
        logic       door_open;
        logic       active;
    } tcp_job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/thermostat_compressor_protection_core.sv -----
// Top level of the compressor protection thermostat: register file, front end,
// job queue and back end. Depends on tcp_pkg and the tcp_* modules.
//
//   Channel  Handshake                Word
//   in       in_valid / in_ready      cabinet, board_ok, probe_ok, cabinet_temp,
//                                     compressor_on, heater_on, door_open, minute_of_day
//   out      out_valid / out_ready    compressor_cmd, fan_cmd, heater_cmd, window_active
//   config   APB psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// One word is taken per cycle unless the output stalls; its result is shown after
// the input stage, the job queue and the output register. The rate is set by the
// back end, which reads, updates and writes the cabinet's guard counters per job.
// Reset clears every guard counter at once and loads the register reset values.
// A two-entry queue between front and back end absorbs output stalls; in_ready
// falls only once the queue and the input stage are both full.
`default_nettype none

module thermostat_compressor_protection_core
    import tcp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         cabinet,
    input  wire logic               board_ok,
    input  wire logic               probe_ok,
    input  wire logic signed [7:0]  cabinet_temp,
    input  wire logic               compressor_on,
    input  wire logic               heater_on,
    input  wire logic               door_open,
    input  wire logic [10:0]        minute_of_day,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              compressor_cmd,
    output logic [1:0]              fan_cmd,
    output logic [1:0]              heater_cmd,
    output logic                    window_active
);

    tcp_cfg_t  cfg;
    tcp_item_t in_item;
    tcp_job_t  front_job;
    tcp_job_t  back_job;
    logic      front_valid, front_ready;
    logic      back_valid, back_ready;

    assign pready = 1'b1;

    // Gather the input word.
    assign in_item.cabinet       = cabinet;
    assign in_item.board_ok      = board_ok;
    assign in_item.probe_ok      = probe_ok;
    assign in_item.cabinet_temp  = cabinet_temp;
    assign in_item.compressor_on = compressor_on;
    assign in_item.heater_on     = heater_on;
    assign in_item.door_open     = door_open;
    assign in_item.minute_of_day = minute_of_day;

    tcp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg       (cfg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    tcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    tcp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (back_valid),
        .job_ready      (back_ready),
        .job            (back_job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .compressor_cmd (compressor_cmd),
        .fan_cmd        (fan_cmd),
        .heater_cmd     (heater_cmd),
        .window_active  (window_active)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_regs.sv -----
// APB register file of the thermostat, with the schedule hours divided by 100.
// Depends on tcp_pkg.
`default_nettype none

module tcp_regs
    import tcp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output tcp_cfg_t                cfg
);

    logic [11:0]         start_reg, start_next;
    logic [11:0]         stop_reg, stop_next;
    logic signed [7:0]   target_reg, target_next;
    logic                mode_reg, mode_next;
    logic [HHMM_Q_W-1:0] start_q_reg, start_q_next;
    logic [HHMM_Q_W-1:0] stop_q_reg, stop_q_next;
    logic [1:0]          reg_idx;
    logic                wr_en;
    logic [22:0]         start_prod;
    logic [22:0]         stop_prod;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes.
    always_comb
    begin
        start_next  = start_reg;
        stop_next   = stop_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WIN_START: start_next  = pwdata[11:0];
                REG_WIN_STOP:  stop_next   = pwdata[11:0];
                REG_TARGET:    target_next = signed'(pwdata[7:0]);
                REG_HEAT_MODE: mode_next   = pwdata[0];
                default:       mode_next   = mode_reg;
            endcase
        end
    end

    // Hours of each schedule bound, by reciprocal multiplication. The quotient
    // register follows the schedule register in the next cycle.
    always_comb
    begin
        start_prod   = 23'(start_reg) * 23'(HHMM_RECIP);
        stop_prod    = 23'(stop_reg) * 23'(HHMM_RECIP);
        start_q_next = HHMM_Q_W'(start_prod >> HHMM_SHIFT);
        stop_q_next  = HHMM_Q_W'(stop_prod >> HHMM_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            stop_reg    <= '0;
            target_reg  <= 8'sd5;
            mode_reg    <= 1'b0;
            start_q_reg <= '0;
            stop_q_reg  <= '0;
        end
        else
        begin
            start_reg   <= start_next;
            stop_reg    <= stop_next;
            target_reg  <= target_next;
            mode_reg    <= mode_next;
            start_q_reg <= start_q_next;
            stop_q_reg  <= stop_q_next;
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            REG_WIN_START: prdata = PDATA_W'(start_reg);
            REG_WIN_STOP:  prdata = PDATA_W'(stop_reg);
            REG_TARGET:    prdata = {{(PDATA_W-8){target_reg[7]}}, target_reg};
            REG_HEAT_MODE: prdata = PDATA_W'(mode_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.win_start   = start_reg;
    assign cfg.win_stop    = stop_reg;
    assign cfg.start_q     = start_q_reg;
    assign cfg.stop_q      = stop_q_reg;
    assign cfg.target_temp = target_reg;
    assign cfg.heat_mode   = mode_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_front.sv -----
// Front end: takes input words, checks the schedule window and temperature
// thresholds, and classifies each word into a job. Depends on tcp_pkg.
`default_nettype none

module tcp_front
    import tcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tcp_item_t in_item,
    input  wire tcp_cfg_t  cfg,
    output logic           job_valid,
    input  wire logic      job_ready,
    output tcp_job_t       job
);

    logic              s1_valid_reg, s1_valid_next;
    tcp_item_t         s1_item_reg;
    logic              in_fire;
    logic [11:0]       start_min;
    logic [11:0]       stop_min;
    logic [11:0]       now_min;
    logic              win_on;
    logic              cab_ok;
    logic signed [9:0] temp_w;
    logic signed [9:0] tgt_w;

    assign in_ready  = !s1_valid_reg || job_ready;
    assign in_fire   = in_valid && in_ready;
    assign job_valid = s1_valid_reg;

    // Input stage.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (job_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_item;
    end

    // Schedule bounds in minutes: hhmm - 40 * hours.
    always_comb
    begin
        start_min = cfg.win_start - (12'({cfg.start_q, 5'b0}) + 12'({cfg.start_q, 3'b0}));
        stop_min  = cfg.win_stop - (12'({cfg.stop_q, 5'b0}) + 12'({cfg.stop_q, 3'b0}));
        now_min   = 12'(s1_item_reg.minute_of_day);
    end

    // Window decision, including the always-on and off encodings.
    always_comb
    begin
        if (cfg.win_start == HHMM_ALWAYS_ON && cfg.win_stop == HHMM_ALWAYS_ON)
            win_on = 1'b1;
        else if (cfg.win_start == HHMM_OFF && cfg.win_stop == HHMM_OFF)
            win_on = 1'b0;
        else if (start_min < stop_min)
            win_on = (now_min >= start_min) && (now_min <= stop_min);
        else if (start_min > stop_min)
            win_on = (now_min >= start_min) || (now_min <= stop_min);
        else
            win_on = 1'b0;
    end

    // Temperature comparisons and classification.
    always_comb
    begin
        temp_w = {{2{s1_item_reg.cabinet_temp[7]}}, s1_item_reg.cabinet_temp};
        tgt_w  = {{2{cfg.target_temp[7]}}, cfg.target_temp};
        cab_ok = 32'(s1_item_reg.cabinet) < CABINETS;

        job.cabinet   = s1_item_reg.cabinet;
        job.hot       = temp_w >= (tgt_w + HYST_DEG);
        job.cool_done = temp_w <= tgt_w;
        job.cold      = (temp_w <= (tgt_w - HYST_DEG)) && (temp_w <= HEAT_MAX_DEG);
        job.heat_done = (temp_w > HEAT_MAX_DEG) || (temp_w >= tgt_w);
        job.comp_on   = s1_item_reg.compressor_on;
        job.heat_on   = s1_item_reg.heater_on;
        job.door_open = s1_item_reg.door_open;
        job.active    = win_on;

        if (!cab_ok || !s1_item_reg.board_ok)
            job.cls = CLS_IGNORE;
        else if (!s1_item_reg.probe_ok || !win_on)
            job.cls = CLS_SHUT;
        else if (!cfg.heat_mode)
            job.cls = CLS_COOL;
        else
            job.cls = CLS_HEAT;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_queue.sv -----
// Two-entry job queue between front and back end, so either side may stall.
// Depends on tcp_pkg.
`default_nettype none

module tcp_queue
    import tcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire tcp_job_t push_job,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output tcp_job_t      pop_job
);

    tcp_job_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 2'd1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_back.sv -----
// Back end: updates the cabinet's guard counters and decides the relay
// commands, holding each result word in an output register. Depends on tcp_pkg.
`default_nettype none

module tcp_back
    import tcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    output logic          job_ready,
    input  wire tcp_job_t job,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [1:0]    compressor_cmd,
    output logic [1:0]    fan_cmd,
    output logic [1:0]    heater_cmd,
    output logic          window_active
);

    logic [CNT_W-1:0]     off_cnt_reg [CABINETS];
    logic [CNT_W-1:0]     run_cnt_reg [CABINETS];
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           cc_reg, fc_reg, hc_reg;
    logic                 act_reg;
    logic [1:0]           cc, fc, hc;
    logic [CNT_W-1:0]     off_cur, run_cur;
    logic [CNT_W-1:0]     off_next, run_next;
    logic                 cnt_wr;
    logic                 job_fire;
    logic [CAB_IDX_W-1:0] idx;

    assign job_ready = !out_valid_reg || out_ready;
    assign job_fire  = job_valid && job_ready;
    assign idx       = job.cabinet[CAB_IDX_W-1:0];
    assign off_cur   = off_cnt_reg[idx];
    assign run_cur   = run_cnt_reg[idx];

    // Relay decisions and counter updates for one tick.
    always_comb
    begin
        cc       = CMD_NONE;
        fc       = CMD_NONE;
        hc       = CMD_NONE;
        off_next = off_cur;
        run_next = run_cur;
        cnt_wr   = 1'b0;
        case (job.cls)
            CLS_SHUT:
            begin
                cc = CMD_OFF;
                fc = CMD_OFF;
                hc = CMD_OFF;
            end
            CLS_COOL:
            begin
                cnt_wr = 1'b1;
                if (job.heat_on)
                    hc = CMD_OFF;
                if (!job.comp_on)
                begin
                    off_next = (off_cur != CNT_MAX) ? off_cur + 1'b1 : off_cur;
                    if (job.hot)
                    begin
                        fc = CMD_ON;
                        if (!job.door_open && off_next > OFF_GUARD_MIN)
                        begin
                            run_next = '0;
                            cc       = CMD_ON;
                        end
                    end
                end
                else
                begin
                    run_next = (run_cur != CNT_MAX) ? run_cur + 1'b1 : run_cur;
                    if (job.door_open)
                    begin
                        cc       = CMD_OFF;
                        off_next = '0;
                    end
                    else
                    begin
                        if (run_next >= RUN_LIMIT)
                        begin
                            cc       = CMD_OFF;
                            off_next = '0;
                        end
                        if (job.cool_done)
                        begin
                            cc       = CMD_OFF;
                            fc       = CMD_OFF;
                            off_next = '0;
                        end
                    end
                end
            end
            CLS_HEAT:
            begin
                cnt_wr   = 1'b1;
                off_next = '0;
                run_next = '0;
                if (job.comp_on)
                    cc = CMD_OFF;
                if (!job.heat_on)
                begin
                    if (job.cold)
                    begin
                        fc = CMD_ON;
                        if (!job.door_open)
                            hc = CMD_ON;
                    end
                end
                else if (job.door_open)
                    hc = CMD_OFF;
                else if (job.heat_done)
                begin
                    hc = CMD_OFF;
                    fc = CMD_OFF;
                end
            end
            default:
            begin
                cnt_wr = 1'b0;
            end
        endcase
    end

    // Guard counters, one pair per cabinet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CABINETS; i++)
            begin
                off_cnt_reg[i] <= '0;
                run_cnt_reg[i] <= '0;
            end
        end
        else if (job_fire && cnt_wr)
        begin
            off_cnt_reg[idx] <= off_next;
            run_cnt_reg[idx] <= run_next;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (job_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (job_fire)
        begin
            cc_reg  <= cc;
            fc_reg  <= fc;
            hc_reg  <= hc;
            act_reg <= job.active;
        end
    end

    assign out_valid      = out_valid_reg;
    assign compressor_cmd = cc_reg;
    assign fan_cmd        = fc_reg;
    assign heater_cmd     = hc_reg;
    assign window_active  = act_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tcp_checker.sv -----
// Port-level checks of the thermostat's result channel, bound to the top level.
// Depends on tcp_pkg.
`default_nettype none

module tcp_checker
    import tcp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] compressor_cmd,
    input wire logic [1:0] fan_cmd,
    input wire logic [1:0] heater_cmd,
    input wire logic       window_active
);

    // A stalled word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled word keeps its contents.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(compressor_cmd) && $stable(fan_cmd)
            && $stable(heater_cmd) && $stable(window_active))
        else $error("result word changed while stalled");

    // Outside the window every relay gets the same command, and never a start.
    a_window_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_active |-> compressor_cmd == fan_cmd
            && heater_cmd == fan_cmd && (fan_cmd == CMD_NONE || fan_cmd == CMD_OFF))
        else $error("relay started or split outside the schedule window");

    // The compressor never starts without the fan.
    a_comp_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compressor_cmd == CMD_ON |-> fan_cmd == CMD_ON)
        else $error("compressor started without the fan");

    // The heater never starts without the fan, nor together with the compressor.
    a_heat_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && heater_cmd == CMD_ON |-> fan_cmd == CMD_ON
            && compressor_cmd != CMD_ON)
        else $error("heater started without the fan or with the compressor");

endmodule

bind thermostat_compressor_protection_core tcp_checker u_tcp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .compressor_cmd (compressor_cmd),
    .fan_cmd        (fan_cmd),
    .heater_cmd     (heater_cmd),
    .window_active  (window_active)
);

`default_nettype wire
